[sv/keypad_event_held_key_tracker_assert.svh]
// Assertion helpers for the held-key tracker. Both expect clk in scope; KHT_ASSERT also expects rst.
`ifndef KEYPAD_EVENT_HELD_KEY_TRACKER_ASSERT_SVH
`define KEYPAD_EVENT_HELD_KEY_TRACKER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define KHT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define KHT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/kht_pkg.sv]
package kht_pkg;

  localparam int MAX_HELD_DEF   = 16;
  localparam int KEY_STRIDE_DEF = 10;
  localparam int RESULT_CAP     = 16;
  localparam int CODE_LIMIT     = 70;
  localparam int ROW_COUNT      = 7;
  localparam int COL_COUNT      = 8;

  localparam logic [1:0] REQ_EVENT = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_INVALID  = 3'd1,
    ST_FULL     = 3'd2,
    ST_ENTRY    = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_DISABLED = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_APPLY,
    S_READ
  } state_t;

  typedef enum logic [1:0] {
    OP_FIXED,
    OP_CLEAR,
    OP_PRESS,
    OP_RELEASE
  } op_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_CLOSE,
    CELL_ROTATE
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t  cmd;
    logic [5:0] key;
  } cell_ctrl_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] event_code;
  } req_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] key_col_x;
    logic [1:0] key_row_y;
    logic [4:0] held_count;
    logic       last_item;
  } rsp_item_t;

  // Returns {valid, x[3:0], y[1:0]} for an event byte.
  function automatic logic [6:0] key_decode(logic [7:0] code, int stride);
    logic [6:0] raw;
    logic [6:0] key;
    logic [3:0] row;
    logic [6:0] col;
    logic       ok;
    raw = code[6:0];
    key = raw - 7'd1;
    row = '0;
    // Row is the count of stride multiples at or below the key, capped at COL_COUNT.
    for (int r = 1; r <= COL_COUNT; r++) begin
      if (int'(key) >= r * stride) begin
        row = row + 4'd1;
      end
    end
    col = key - 7'(int'(row) * stride);
    ok  = (raw != 7'd0) && (int'(key) < CODE_LIMIT) && (int'(row) < ROW_COUNT) &&
          (int'(col) < COL_COUNT);
    return {ok, row[2:0], col[2], col[1:0]};
  endfunction

endpackage

[sv/kht_cell.sv]
module kht_cell #(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic                clk,
  input  kht_pkg::cell_ctrl_t ctrl,
  input  logic [CW-1:0]       count,
  input  logic [CW-1:0]       midx,
  input  logic [5:0]          nbr,
  input  logic [5:0]          head,
  output logic [5:0]          entry,
  output logic                hit
);

  localparam logic [CW-1:0] ID = CW'(IDX);

  logic occupied;

  assign occupied = ID < count;
  assign hit      = occupied && (entry == ctrl.key);

  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      kht_pkg::CELL_LOAD: begin
        if (ID == count) begin
          entry <= ctrl.key;
        end
      end
      kht_pkg::CELL_CLOSE: begin
        // close the gap left by the released key
        if (ID >= midx) begin
          entry <= nbr;
        end
      end
      kht_pkg::CELL_ROTATE: begin
        // the last held cell wraps around to the head
        if (ID == count - CW'(1)) begin
          entry <= head;
        end else if (occupied) begin
          entry <= nbr;
        end
      end
      default: begin
        entry <= entry;
      end
    endcase
  end

endmodule

[sv/keypad_event_held_key_tracker.sv]
// Held-key tracker: takes keypad event requests (key event, overflow clear, list read) and
// keeps the held keys in press order in a chain of MAX_HELD cells. A key event or clear passes
// through accept, parallel compare against all cells, and update and response; a read sends
// the list from the chain head, one entry a cycle unless the response side stalls, while the
// chain rotates once all the way round, so a read holds the block until the rotation ends,
// even when only the first 16 are returned. Response backpressure stalls both kinds of request.
// The enable register is written through cfg, which is always ready; write it only while idle.
`include "keypad_event_held_key_tracker_assert.svh"

module keypad_event_held_key_tracker #(
  parameter int MAX_HELD   = kht_pkg::MAX_HELD_DEF,
  parameter int KEY_STRIDE = kht_pkg::KEY_STRIDE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  kht_pkg::req_item_t req_data,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output kht_pkg::rsp_item_t rsp_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  localparam int CW = $clog2(MAX_HELD + 1);

  kht_pkg::state_t    state;
  kht_pkg::state_t    state_next;
  kht_pkg::op_t       op;
  kht_pkg::status_t   stat;
  kht_pkg::cell_ctrl_t cell_ctrl;
  kht_pkg::rsp_item_t rsp_next;

  logic [5:0]    key;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] midx;
  logic [CW-1:0] midx_c;
  logic [CW-1:0] rd_cnt;
  logic          hit_any;
  logic          enabled;
  logic          req_fire;
  logic          can_emit;
  logic          emit;
  logic          emit_last;
  logic          rd_step;
  logic          rd_done;
  logic          room;
  logic [6:0]    dec;

  logic [5:0]          entry [MAX_HELD];
  logic [MAX_HELD-1:0] hit;

  assign cfg_ready = 1'b1;
  assign req_stall = state != kht_pkg::S_IDLE;
  assign req_fire  = req_valid && !req_stall;
  assign can_emit  = !rsp_valid || !rsp_stall;
  assign dec       = kht_pkg::key_decode(req_data.event_code, KEY_STRIDE);
  assign room      = int'(count) < MAX_HELD;
  assign rd_done   = rd_cnt == count - CW'(1);
  assign emit_last = emit && rsp_next.last_item;

  // Cell chain
  for (genvar i = 0; i < MAX_HELD; i++) begin : g_cell
    logic [5:0] nbr;
    if (i == MAX_HELD - 1) begin : g_tail
      assign nbr = entry[i];
    end else begin : g_mid
      assign nbr = entry[i+1];
    end
    kht_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk   (clk),
      .ctrl  (cell_ctrl),
      .count (count),
      .midx  (midx),
      .nbr   (nbr),
      .head  (entry[0]),
      .entry (entry[i]),
      .hit   (hit[i])
    );
  end

  // Held keys are unique, so at most one cell hits and an OR gives its index.
  always_comb begin
    midx_c = '0;
    for (int i = 0; i < MAX_HELD; i++) begin
      if (hit[i]) begin
        midx_c = midx_c | CW'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      kht_pkg::S_IDLE: begin
        if (req_fire) begin
          if (enabled && req_data.req_type == kht_pkg::REQ_READ) begin
            state_next = kht_pkg::S_READ;
          end else begin
            state_next = kht_pkg::S_MATCH;
          end
        end
      end
      kht_pkg::S_MATCH: begin
        state_next = kht_pkg::S_APPLY;
      end
      kht_pkg::S_APPLY: begin
        if (can_emit) begin
          state_next = kht_pkg::S_IDLE;
        end
      end
      kht_pkg::S_READ: begin
        if (count == '0) begin
          if (can_emit) begin
            state_next = kht_pkg::S_IDLE;
          end
        end else if (rd_step && rd_done) begin
          state_next = kht_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = kht_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cell_ctrl.cmd       = kht_pkg::CELL_HOLD;
    cell_ctrl.key       = key;
    count_next          = count;
    emit                = 1'b0;
    rd_step             = 1'b0;
    rsp_next.status     = kht_pkg::ST_UPDATED;
    rsp_next.key_col_x  = '0;
    rsp_next.key_row_y  = '0;
    rsp_next.last_item  = 1'b1;
    case (state)
      kht_pkg::S_APPLY: begin
        emit = can_emit;
        case (op)
          kht_pkg::OP_FIXED: begin
            rsp_next.status = stat;
          end
          kht_pkg::OP_CLEAR: begin
            count_next = '0;
          end
          kht_pkg::OP_PRESS: begin
            if (!hit_any) begin
              if (room) begin
                cell_ctrl.cmd = kht_pkg::CELL_LOAD;
                count_next    = count + CW'(1);
              end else begin
                rsp_next.status = kht_pkg::ST_FULL;
              end
            end
          end
          kht_pkg::OP_RELEASE: begin
            if (hit_any) begin
              cell_ctrl.cmd = kht_pkg::CELL_CLOSE;
              count_next    = count - CW'(1);
            end
          end
          default: begin
            rsp_next.status = kht_pkg::ST_INVALID;
          end
        endcase
        // hold the chain while the response register is full
        if (!can_emit) begin
          cell_ctrl.cmd = kht_pkg::CELL_HOLD;
          count_next    = count;
        end
      end
      kht_pkg::S_READ: begin
        if (count == '0) begin
          emit            = can_emit;
          rsp_next.status = kht_pkg::ST_EMPTY;
        end else begin
          rsp_next.status    = kht_pkg::ST_ENTRY;
          rsp_next.key_col_x = entry[0][5:2];
          rsp_next.key_row_y = entry[0][1:0];
          rsp_next.last_item = rd_done || (int'(rd_cnt) == kht_pkg::RESULT_CAP - 1);
          if (int'(rd_cnt) < kht_pkg::RESULT_CAP) begin
            emit    = can_emit;
            rd_step = can_emit;
          end else begin
            // past the response cap: finish the rotation silently
            rd_step = 1'b1;
          end
          if (rd_step) begin
            cell_ctrl.cmd = kht_pkg::CELL_ROTATE;
          end
        end
      end
      default: begin
        cell_ctrl.cmd = kht_pkg::CELL_HOLD;
      end
    endcase
    rsp_next.held_count = 5'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kht_pkg::S_IDLE;
      count     <= '0;
      rd_cnt    <= '0;
      enabled   <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_valid && cfg_ready) begin
        enabled <= cfg_data;
      end
      if (state != kht_pkg::S_READ) begin
        rd_cnt <= '0;
      end else if (rd_step) begin
        rd_cnt <= rd_cnt + CW'(1);
      end
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      key <= dec[5:0];
      if (!enabled) begin
        op   <= kht_pkg::OP_FIXED;
        stat <= kht_pkg::ST_DISABLED;
      end else if (req_data.req_type == kht_pkg::REQ_EVENT) begin
        stat <= kht_pkg::ST_INVALID;
        if (!dec[6]) begin
          op <= kht_pkg::OP_FIXED;
        end else if (req_data.event_code[7]) begin
          op <= kht_pkg::OP_PRESS;
        end else begin
          op <= kht_pkg::OP_RELEASE;
        end
      end else if (req_data.req_type == kht_pkg::REQ_CLEAR) begin
        op   <= kht_pkg::OP_CLEAR;
        stat <= kht_pkg::ST_UPDATED;
      end else begin
        op   <= kht_pkg::OP_FIXED;
        stat <= kht_pkg::ST_INVALID;
      end
    end
    if (state == kht_pkg::S_MATCH) begin
      hit_any <= |hit;
      midx    <= midx_c;
    end
    if (emit) begin
      rsp_data <= rsp_next;
    end
  end

  `KHT_ASSERT(a_count_bound, int'(count) <= MAX_HELD, "held count exceeds capacity")
  `KHT_ASSERT(a_count_apply_only, (state != kht_pkg::S_APPLY) |=> count == $past(count), "held count changed outside update")
  `KHT_ASSERT(a_last_ends_request, emit_last |=> state == kht_pkg::S_IDLE, "last response did not end the request")
  `KHT_ASSERT(a_idle_after_last, $rose(state == kht_pkg::S_IDLE) |-> $past(emit_last), "request ended without a last response")

endmodule

[verif/keypad_event_held_key_tracker_tb.sv]
`timescale 1ns / 100ps

module keypad_event_held_key_tracker_tb;

  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam logic [7:0] PRESS_BIT   = 8'h80;
  localparam int         STRIDE      = kht_pkg::KEY_STRIDE_DEF;
  localparam int         CFG_SETTLE  = 24;
  localparam int         END_SETTLE  = 40;
  localparam int         MAX_REPORTS = 10;

  // Mirrors the held-key list and enable bit, and checks responses in order.
  class held_key_scoreboard;
    logic [5:0]         held_coords[$];
    bit                 enabled;
    kht_pkg::rsp_item_t expected_rsp[$];
    int                 mismatches;
    int                 requests_seen;
    int                 results_seen;
    int                 status_hits[6];

    function new();
      enabled       = 1'b1;
      mismatches    = 0;
      requests_seen = 0;
      results_seen  = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction

    function kht_pkg::status_t apply_event(logic [7:0] code);
      int raw;
      int key;
      int row;
      int col;
      int idx;
      logic [5:0] coor;
      raw = int'(code[6:0]);
      if (raw == 0) return kht_pkg::ST_INVALID;
      key = raw - 1;
      if (key >= kht_pkg::CODE_LIMIT) return kht_pkg::ST_INVALID;
      row = key / STRIDE;
      col = key % STRIDE;
      if (row >= kht_pkg::ROW_COUNT || col >= kht_pkg::COL_COUNT) return kht_pkg::ST_INVALID;
      coor = {4'(row * 2 + ((col > 3) ? 1 : 0)), 2'(col % 4)};
      idx = -1;
      foreach (held_coords[i]) begin
        if (idx < 0 && held_coords[i] == coor) idx = i;
      end
      if (code[7]) begin
        if (idx >= 0) return kht_pkg::ST_UPDATED;
        if (held_coords.size() >= kht_pkg::MAX_HELD_DEF) return kht_pkg::ST_FULL;
        held_coords = {held_coords, coor};
        return kht_pkg::ST_UPDATED;
      end
      // close up behind the first match
      if (idx >= 0) held_coords.delete(idx);
      return kht_pkg::ST_UPDATED;
    endfunction

    function void predict_request(kht_pkg::req_item_t r);
      kht_pkg::rsp_item_t want;
      kht_pkg::status_t   st;
      int                 n;
      requests_seen++;
      want = '0;
      want.last_item = 1'b1;
      if (!enabled) begin
        st = kht_pkg::ST_DISABLED;
      end else begin
        case (r.req_type)
          kht_pkg::REQ_EVENT: st = apply_event(r.event_code);
          kht_pkg::REQ_CLEAR: begin
            held_coords.delete();
            st = kht_pkg::ST_UPDATED;
          end
          kht_pkg::REQ_READ: begin
            n = held_coords.size();
            if (n > kht_pkg::RESULT_CAP) n = kht_pkg::RESULT_CAP;
            if (n == 0) begin
              st = kht_pkg::ST_EMPTY;
            end else begin
              for (int i = 0; i < n; i++) begin
                want.status     = kht_pkg::ST_ENTRY;
                want.key_col_x  = held_coords[i][5:2];
                want.key_row_y  = held_coords[i][1:0];
                want.held_count = 5'(held_coords.size());
                want.last_item  = (i == n - 1);
                expected_rsp = {expected_rsp, want};
              end
              return;
            end
          end
          default: st = kht_pkg::ST_INVALID;
        endcase
      end
      want.status     = st;
      want.held_count = 5'(held_coords.size());
      expected_rsp = {expected_rsp, want};
    endfunction

    function void report(string what, kht_pkg::rsp_item_t want, kht_pkg::rsp_item_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("MISMATCH %s: want st=%0d x=%0d y=%0d cnt=%0d last=%0b,",
                 what, want.status, want.key_col_x, want.key_row_y, want.held_count,
                 want.last_item);
        $display("  got st=%0d x=%0d y=%0d cnt=%0d last=%0b",
                 got.status, got.key_col_x, got.key_row_y, got.held_count, got.last_item);
      end
    endfunction

    function void check_result(kht_pkg::rsp_item_t got);
      kht_pkg::rsp_item_t want;
      results_seen++;
      if (got.status < 3'd6) status_hits[got.status]++;
      if (expected_rsp.size() == 0) begin
        report("response with nothing pending", '0, got);
        return;
      end
      want = expected_rsp.pop_front();
      if (got.status !== want.status || got.key_col_x !== want.key_col_x ||
          got.key_row_y !== want.key_row_y || got.held_count !== want.held_count ||
          got.last_item !== want.last_item) begin
        report("field", want, got);
      end
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  kht_pkg::req_item_t req_data  = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b1;
  kht_pkg::rsp_item_t rsp_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_data  = 1'b0;

  held_key_scoreboard sb;
  bit send_idle_on = 1'b1;
  bit rsp_idle_on  = 1'b1;
  int hold_request = 0;

  keypad_event_held_key_tracker u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #800000;
    $display("keypad_event_held_key_tracker_tb NOT OK");
    $finish;
  end

  // Response side: random stalls, plus a long hold-off when one is requested.
  initial begin : rsp_side
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left == 0 && rsp_idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        rsp_stall <= 1'b1;
        stall_left--;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // Outputs and stall are stable mid-cycle, so sample there for the coming edge.
  always @(negedge clk) begin
    if (!rst && rsp_valid && !rsp_stall && sb != null) sb.check_result(rsp_data);
  end

  function automatic kht_pkg::req_item_t make_req(logic [1:0] kind, logic [7:0] code);
    kht_pkg::req_item_t r;
    r.req_type   = kind;
    r.event_code = code;
    return r;
  endfunction

  function automatic logic [6:0] raw_code(int row, int col);
    return 7'(row * STRIDE + col + 1);
  endfunction

  function automatic kht_pkg::req_item_t random_request();
    kht_pkg::req_item_t r;
    int                 pick;
    int                 row;
    int                 col;
    logic [5:0]         coor;
    pick = $urandom_range(0, 99);
    row  = $urandom_range(0, kht_pkg::ROW_COUNT - 1);
    col  = $urandom_range(0, kht_pkg::COL_COUNT - 1);
    r    = make_req(kht_pkg::REQ_EVENT, PRESS_BIT | raw_code(row, col));
    if (pick < 45) begin
      // press of a valid key, already set up above
    end else if (pick < 70) begin
      if (sb.held_coords.size() > 0 && $urandom_range(0, 9) < 7) begin
        coor = sb.held_coords[$urandom_range(0, sb.held_coords.size() - 1)];
        row  = coor[5:2] / 2;
        col  = (coor[5:2] % 2) * 4 + coor[1:0];
      end
      r.event_code = {1'b0, raw_code(row, col)};
    end else if (pick < 82) begin
      r = make_req(kht_pkg::REQ_READ, 8'($urandom));
    end else if (pick < 86) begin
      r = make_req(kht_pkg::REQ_CLEAR, 8'($urandom));
    end else if (pick < 92) begin
      r.event_code = 8'($urandom);
    end else if (pick < 95) begin
      r = make_req(REQ_UNUSED, 8'($urandom));
    end else begin
      // decodes out of the grid: bad column, code past the end, or code zero
      case ($urandom_range(0, 2))
        0:       r.event_code[6:0] = 7'(row * STRIDE + 8 + $urandom_range(0, 1) + 1);
        1:       r.event_code[6:0] = 7'($urandom_range(kht_pkg::CODE_LIMIT + 1, 127));
        default: r.event_code[6:0] = 7'd0;
      endcase
      r.event_code[7] = 1'($urandom);
    end
    return r;
  endfunction

  // Offer one request and return at the edge that takes it; valid stays up.
  task automatic send_request(kht_pkg::req_item_t r);
    bit taken;
    req_valid <= 1'b1;
    req_data  <= r;
    forever begin
      @(negedge clk);
      taken = !req_stall;
      @(posedge clk);
      if (taken) break;
    end
    sb.predict_request(r);
  endtask

  task automatic sender_pause();
    int n;
    int pick;
    n = 0;
    if (send_idle_on) begin
      pick = $urandom_range(0, 9);
      n = (pick < 5) ? 0 : (pick < 9) ? $urandom_range(1, 3) : $urandom_range(8, 25);
    end
    if (n > 0) begin
      req_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_results_home();
    req_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic write_enable(bit value);
    bit taken;
    wait_results_home();
    // a long read keeps rotating the list after its last entry leaves
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    forever begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
      if (taken) break;
    end
    sb.enabled = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(int count);
    repeat (count) begin
      send_request(random_request());
      sender_pause();
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_enable(1'b1);

    // directed: corners of the decode, duplicates, full list, read, clear
    send_request(make_req(kht_pkg::REQ_EVENT, PRESS_BIT | raw_code(0, 0)));
    send_request(make_req(kht_pkg::REQ_EVENT, PRESS_BIT | raw_code(0, 0)));
    send_request(make_req(kht_pkg::REQ_EVENT,
                          PRESS_BIT | raw_code(kht_pkg::ROW_COUNT - 1, kht_pkg::COL_COUNT - 1)));
    send_request(make_req(kht_pkg::REQ_EVENT, PRESS_BIT));
    send_request(make_req(kht_pkg::REQ_EVENT, 8'hFF));
    send_request(make_req(kht_pkg::REQ_EVENT, PRESS_BIT | raw_code(kht_pkg::ROW_COUNT - 1, 9)));
    send_request(make_req(kht_pkg::REQ_EVENT, PRESS_BIT | 7'(kht_pkg::CODE_LIMIT + 1)));
    send_request(make_req(kht_pkg::REQ_EVENT, PRESS_BIT | raw_code(0, 8)));
    send_request(make_req(kht_pkg::REQ_EVENT, {1'b0, raw_code(0, 4)}));
    send_request(make_req(REQ_UNUSED, 8'h7F));
    for (int i = 0; i < kht_pkg::MAX_HELD_DEF - 2; i++) begin
      send_request(make_req(kht_pkg::REQ_EVENT, PRESS_BIT | raw_code(1 + i / 8, i % 8)));
      sender_pause();
    end
    send_request(make_req(kht_pkg::REQ_EVENT, PRESS_BIT | raw_code(5, 0)));
    send_request(make_req(kht_pkg::REQ_READ, 8'h00));
    send_request(make_req(kht_pkg::REQ_EVENT, {1'b0, raw_code(0, 0)}));
    send_request(make_req(kht_pkg::REQ_CLEAR, 8'h00));
    send_request(make_req(kht_pkg::REQ_READ, 8'hFF));

    run_random(35);

    // hold responses off while requests keep coming, then let everything drain
    wait_results_home();
    hold_request = 150;
    send_idle_on = 1'b0;
    run_random(25);
    wait_results_home();
    send_idle_on = 1'b1;

    write_enable(1'b0);
    repeat (12) begin
      send_request(make_req(2'($urandom), 8'($urandom)));
      sender_pause();
    end
    write_enable(1'b1);

    send_idle_on = 1'b0;
    rsp_idle_on  = 1'b0;
    run_random(30);
    send_idle_on = 1'b1;
    rsp_idle_on  = 1'b1;
    run_random(30);

    wait_results_home();
    repeat (END_SETTLE) @(posedge clk);
    if (sb.pending() != 0) sb.mismatches++;
    $display("Covered %0d requests, %0d responses: %0d list entries, %0d empty reads,",
             sb.requests_seen, sb.results_seen,
             sb.status_hits[int'(kht_pkg::ST_ENTRY)],
             sb.status_hits[int'(kht_pkg::ST_EMPTY)]);
    $display("  %0d full-list drops, %0d invalid, %0d disabled; %0d mismatches",
             sb.status_hits[int'(kht_pkg::ST_FULL)],
             sb.status_hits[int'(kht_pkg::ST_INVALID)],
             sb.status_hits[int'(kht_pkg::ST_DISABLED)], sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("keypad_event_held_key_tracker_tb OK");
    end else begin
      $display("keypad_event_held_key_tracker_tb NOT OK");
    end
    $finish;
  end

endmodule
